// ----- hdl/phm_pkg.sv -----
`default_nettype none

package phm_pkg;

    localparam int IN_W     = 200;
    localparam int OUT_W    = 80;
    localparam int KEY_W    = 64;
    localparam int VAL_W    = 64;
    localparam int LIVE_W   = 11;
    localparam int USABLE_W = 17;

    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_LIVE  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    localparam logic [1:0] OP_GET = 2'd0;
    localparam logic [1:0] OP_SET = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PRD,
        S_PCHK,
        S_ACT,
        S_RSIZE,
        S_RCLR,
        S_RSRD,
        S_RSCHK,
        S_RPUT,
        S_RFIN,
        S_RETRY,
        S_INS,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PM_MAIN,
        PM_REB,
        PM_RETRY
    } pmode_t;

    // Slots that may be filled in a table of 2**lg slots: (2*size+1)/3.
    function automatic logic [USABLE_W-1:0] usable_of(input logic [4:0] lg);
        logic [USABLE_W-1:0] u;
        unique case (lg)
            5'd0:  u = 17'd1;
            5'd1:  u = 17'd1;
            5'd2:  u = 17'd3;
            5'd3:  u = 17'd5;
            5'd4:  u = 17'd11;
            5'd5:  u = 17'd21;
            5'd6:  u = 17'd43;
            5'd7:  u = 17'd85;
            5'd8:  u = 17'd171;
            5'd9:  u = 17'd341;
            5'd10: u = 17'd683;
            5'd11: u = 17'd1365;
            5'd12: u = 17'd2731;
            5'd13: u = 17'd5461;
            5'd14: u = 17'd10923;
            5'd15: u = 17'd21845;
            5'd16: u = 17'd43691;
            default: u = 17'd0;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/perturbed_probe_hash_map.sv -----
`default_nettype none
// Key/value map held in an open-addressed table with perturbed probing.
// The slave channel takes one request beat; the master channel returns one
// result beat for it. The block handles one request at a time: s_tready is
// high only while it is idle, and it stays low until the result beat has
// been taken, so a stalled receiver simply holds the block in that state.
// Each probed slot is read and then checked; then a decision state, which
// writes a hit's value or a delete's tombstone, and for a new key an insert
// state come before the result beat is offered, as the slot memories have a
// single registered read port. The block passes through the idle state
// before the next request beat is taken. A set that would fill an empty slot
// while no usable slot is left first rebuilds the table into the other bank:
// the target size is found, the new bank is cleared slot by slot, and every
// old slot is read, with each live key probed and written into the new
// table, before the key is probed again in the new table.
// After reset the tag memory of the first bank is cleared, one slot per
// cycle; s_tready stays low during that pass.
module perturbed_probe_hash_map #(
    parameter int MAX_SLOTS    = 1024,
    parameter int MIN_SLOTS    = 8,
    parameter int PERTURB_BITS = 5
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // opcode[1:0], key[65:2], key_hash[129:66], value[193:130], zero pad.
    input  wire logic [phm_pkg::IN_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // found[0], value_out[64:1], status[66:65], live_entries[77:67], zero pad.
    output logic [phm_pkg::OUT_W-1:0]     m_tdata
);

    localparam int IW     = $clog2(MAX_SLOTS);
    localparam int AW     = IW + 1;
    localparam int CW     = $clog2(MAX_SLOTS + 1);
    localparam int NW     = $clog2(MAX_SLOTS + 66);
    localparam int LGW    = $clog2(IW + 1);
    localparam int SW     = IW + 2;
    localparam int MIN_LG = $clog2(MIN_SLOTS);
    localparam int DEPTH  = 2 * MAX_SLOTS;
    localparam int KW     = phm_pkg::KEY_W;
    localparam int VW     = phm_pkg::VAL_W;
    localparam int UW     = phm_pkg::USABLE_W;

    logic [1:0]    tag_mem  [DEPTH];
    logic [KW-1:0] key_mem  [DEPTH];
    logic [KW-1:0] hash_mem [DEPTH];
    logic [VW-1:0] val_mem  [DEPTH];

    logic [1:0]    rd_tag;
    logic [KW-1:0] rd_key;
    logic [KW-1:0] rd_hash;
    logic [VW-1:0] rd_val;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          tag_we;
    logic          kv_we;
    logic          val_we;
    logic [AW-1:0] wr_addr;
    logic [1:0]    wr_tag;
    logic [KW-1:0] wr_key;
    logic [KW-1:0] wr_hash;
    logic [VW-1:0] wr_val;

    phm_pkg::state_t state_reg, state_next;
    phm_pkg::pmode_t p_mode_reg, p_mode_next;

    logic [IW-1:0]  cnt_reg, cnt_next;
    logic [LGW-1:0] lg_reg, lg_next;
    logic [LGW-1:0] nlg_reg, nlg_next;
    logic           ab_reg, ab_next;
    logic [CW-1:0]  live_reg, live_next;
    logic [CW-1:0]  usable_reg, usable_next;

    logic [IW-1:0]  p_idx_reg, p_idx_next;
    logic [KW-1:0]  p_pert_reg, p_pert_next;
    logic [NW-1:0]  p_n_reg, p_n_next;
    logic           p_hf_reg, p_hf_next;
    logic [AW-1:0]  p_free_reg, p_free_next;
    logic           p_bank_reg, p_bank_next;
    logic [LGW-1:0] p_lg_reg, p_lg_next;
    logic [KW-1:0]  p_key_reg, p_key_next;
    logic [KW-1:0]  p_hash_reg, p_hash_next;

    logic           pr_hit_reg, pr_hit_next;
    logic           pr_miss_reg, pr_miss_next;
    logic           pr_empty_reg, pr_empty_next;
    logic [AW-1:0]  slot_reg, slot_next;
    logic [VW-1:0]  pr_val_reg, pr_val_next;

    logic [1:0]     req_op_reg, req_op_next;
    logic [KW-1:0]  req_key_reg, req_key_next;
    logic [KW-1:0]  req_hash_reg, req_hash_next;
    logic [VW-1:0]  req_val_reg, req_val_next;
    logic [KW-1:0]  mv_key_reg, mv_key_next;
    logic [KW-1:0]  mv_hash_reg, mv_hash_next;
    logic [VW-1:0]  mv_val_reg, mv_val_next;

    logic           o_found_reg, o_found_next;
    logic [VW-1:0]  o_val_reg, o_val_next;
    logic [1:0]     o_status_reg, o_status_next;

    logic            start;
    phm_pkg::pmode_t start_mode;
    logic [KW-1:0]   start_key;
    logic [KW-1:0]   start_hash;
    logic            start_bank;
    logic [LGW-1:0]  start_lg;
    logic            fin;
    logic            fin_found;
    logic [VW-1:0]   fin_val;
    logic [1:0]      fin_status;

    logic [IW-1:0] p_mask;
    logic [IW-1:0] lg_mask;
    logic [IW-1:0] nlg_mask;
    logic [AW-1:0] cur_addr;
    logic [IW-1:0] idx_step;
    logic [NW-1:0] p_limit;
    logic          is_match;
    logic          not_live;
    logic          hf_n;
    logic [AW-1:0] free_n;
    logic [SW-1:0] minused;
    logic [SW-1:0] ns_w;
    logic [UW-1:0] new_usable;
    logic          scan_last;

    assign p_mask   = ~({IW{1'b1}} << p_lg_reg);
    assign lg_mask  = ~({IW{1'b1}} << lg_reg);
    assign nlg_mask = ~({IW{1'b1}} << nlg_reg);
    assign cur_addr = {p_bank_reg, p_idx_reg & p_mask};
    assign idx_step = {p_idx_reg[IW-3:0], 2'b00} + p_idx_reg + p_pert_reg[IW-1:0] + IW'(1);
    assign p_limit  = NW'(65) + (NW'(1) << p_lg_reg);
    assign not_live = (rd_tag != phm_pkg::TAG_LIVE);
    assign is_match = !not_live && (rd_hash == p_hash_reg) && (rd_key == p_key_reg);
    assign hf_n     = p_hf_reg | (not_live && (rd_tag != phm_pkg::TAG_EMPTY));
    assign free_n   = (!p_hf_reg && not_live) ? cur_addr : p_free_reg;
    assign minused  = (SW'(live_reg) << 1) + ((SW'(1) << lg_reg) >> 1);
    assign ns_w     = SW'(1) << nlg_reg;
    assign new_usable = phm_pkg::usable_of(5'(nlg_reg));
    assign scan_last  = (cnt_reg == lg_mask);

    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[wr_addr] <= wr_tag;
        end
        if (kv_we) begin
            key_mem[wr_addr]  <= wr_key;
            hash_mem[wr_addr] <= wr_hash;
        end
        if (val_we) begin
            val_mem[wr_addr] <= wr_val;
        end
        if (rd_en) begin
            rd_tag  <= tag_mem[rd_addr];
            rd_key  <= key_mem[rd_addr];
            rd_hash <= hash_mem[rd_addr];
            rd_val  <= val_mem[rd_addr];
        end
    end

    always_comb begin
        state_next    = state_reg;
        p_mode_next   = p_mode_reg;
        cnt_next      = cnt_reg;
        lg_next       = lg_reg;
        nlg_next      = nlg_reg;
        ab_next       = ab_reg;
        live_next     = live_reg;
        usable_next   = usable_reg;
        p_idx_next    = p_idx_reg;
        p_pert_next   = p_pert_reg;
        p_n_next      = p_n_reg;
        p_hf_next     = p_hf_reg;
        p_free_next   = p_free_reg;
        p_bank_next   = p_bank_reg;
        p_lg_next     = p_lg_reg;
        p_key_next    = p_key_reg;
        p_hash_next   = p_hash_reg;
        pr_hit_next   = pr_hit_reg;
        pr_miss_next  = pr_miss_reg;
        pr_empty_next = pr_empty_reg;
        slot_next     = slot_reg;
        pr_val_next   = pr_val_reg;
        req_op_next   = req_op_reg;
        req_key_next  = req_key_reg;
        req_hash_next = req_hash_reg;
        req_val_next  = req_val_reg;
        mv_key_next   = mv_key_reg;
        mv_hash_next  = mv_hash_reg;
        mv_val_next   = mv_val_reg;
        o_found_next  = o_found_reg;
        o_val_next    = o_val_reg;
        o_status_next = o_status_reg;

        s_tready = 1'b0;
        m_tvalid = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = cur_addr;
        tag_we   = 1'b0;
        kv_we    = 1'b0;
        val_we   = 1'b0;
        wr_addr  = slot_reg;
        wr_tag   = phm_pkg::TAG_LIVE;
        wr_key   = req_key_reg;
        wr_hash  = req_hash_reg;
        wr_val   = req_val_reg;

        start      = 1'b0;
        start_mode = phm_pkg::PM_MAIN;
        start_key  = req_key_reg;
        start_hash = req_hash_reg;
        start_bank = ab_reg;
        start_lg   = lg_reg;
        fin        = 1'b0;
        fin_found  = 1'b0;
        fin_val    = '0;
        fin_status = phm_pkg::ST_DONE;

        unique case (state_reg)
            phm_pkg::S_CLEAR: begin
                tag_we   = 1'b1;
                wr_addr  = {1'b0, cnt_reg};
                wr_tag   = phm_pkg::TAG_EMPTY;
                cnt_next = cnt_reg + IW'(1);
                if (cnt_reg == {IW{1'b1}}) begin
                    state_next = phm_pkg::S_IDLE;
                end
            end
            phm_pkg::S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    req_op_next   = s_tdata[1:0];
                    req_key_next  = s_tdata[65:2];
                    req_hash_next = s_tdata[129:66];
                    req_val_next  = s_tdata[193:130];
                    start         = 1'b1;
                    start_key     = s_tdata[65:2];
                    start_hash    = s_tdata[129:66];
                end
            end
            phm_pkg::S_PRD: begin
                rd_en      = 1'b1;
                state_next = phm_pkg::S_PCHK;
            end
            phm_pkg::S_PCHK: begin
                if (rd_tag == phm_pkg::TAG_EMPTY || is_match || p_n_reg + NW'(1) == p_limit) begin
                    if (rd_tag == phm_pkg::TAG_EMPTY) begin
                        pr_hit_next   = 1'b0;
                        pr_miss_next  = 1'b1;
                        pr_empty_next = !p_hf_reg;
                        slot_next     = p_hf_reg ? p_free_reg : cur_addr;
                    end else if (is_match) begin
                        pr_hit_next  = 1'b1;
                        pr_miss_next = 1'b0;
                        slot_next    = cur_addr;
                        pr_val_next  = rd_val;
                    end else begin
                        pr_hit_next   = 1'b0;
                        pr_miss_next  = hf_n;
                        pr_empty_next = 1'b0;
                        slot_next     = free_n;
                    end
                    unique case (p_mode_reg)
                        phm_pkg::PM_REB:   state_next = phm_pkg::S_RPUT;
                        phm_pkg::PM_RETRY: state_next = phm_pkg::S_RETRY;
                        default:           state_next = phm_pkg::S_ACT;
                    endcase
                end else begin
                    p_hf_next   = hf_n;
                    p_free_next = free_n;
                    p_idx_next  = idx_step;
                    p_pert_next = p_pert_reg >> PERTURB_BITS;
                    p_n_next    = p_n_reg + NW'(1);
                    state_next  = phm_pkg::S_PRD;
                end
            end
            phm_pkg::S_ACT: begin
                if (req_op_reg == phm_pkg::OP_SET) begin
                    if (pr_hit_reg) begin
                        val_we = 1'b1;
                        fin       = 1'b1;
                        fin_found = 1'b1;
                    end else if (pr_miss_reg && pr_empty_reg && usable_reg == '0) begin
                        nlg_next   = LGW'(MIN_LG);
                        state_next = phm_pkg::S_RSIZE;
                    end else if (pr_miss_reg) begin
                        state_next = phm_pkg::S_INS;
                    end else begin
                        fin        = 1'b1;
                        fin_status = phm_pkg::ST_FULL;
                    end
                end else if (req_op_reg == phm_pkg::OP_DEL) begin
                    fin = 1'b1;
                    if (pr_hit_reg) begin
                        tag_we    = 1'b1;
                        wr_tag    = phm_pkg::TAG_TOMB;
                        live_next = live_reg - CW'(1);
                        fin_found = 1'b1;
                    end else begin
                        fin_status = phm_pkg::ST_ABSENT;
                    end
                end else begin
                    fin = 1'b1;
                    if (pr_hit_reg) begin
                        fin_found = 1'b1;
                        fin_val   = pr_val_reg;
                    end else begin
                        fin_status = phm_pkg::ST_ABSENT;
                    end
                end
            end
            phm_pkg::S_RSIZE: begin
                if (ns_w <= minused && nlg_reg < LGW'(IW)) begin
                    nlg_next = nlg_reg + LGW'(1);
                end else if (new_usable <= UW'(live_reg)) begin
                    fin        = 1'b1;
                    fin_status = phm_pkg::ST_FULL;
                end else begin
                    cnt_next   = '0;
                    state_next = phm_pkg::S_RCLR;
                end
            end
            phm_pkg::S_RCLR: begin
                tag_we   = 1'b1;
                wr_addr  = {~ab_reg, cnt_reg};
                wr_tag   = phm_pkg::TAG_EMPTY;
                cnt_next = cnt_reg + IW'(1);
                if (cnt_reg == nlg_mask) begin
                    cnt_next   = '0;
                    state_next = phm_pkg::S_RSRD;
                end
            end
            phm_pkg::S_RSRD: begin
                rd_en      = 1'b1;
                rd_addr    = {ab_reg, cnt_reg};
                state_next = phm_pkg::S_RSCHK;
            end
            phm_pkg::S_RSCHK: begin
                if (rd_tag == phm_pkg::TAG_LIVE) begin
                    mv_key_next  = rd_key;
                    mv_hash_next = rd_hash;
                    mv_val_next  = rd_val;
                    start        = 1'b1;
                    start_mode   = phm_pkg::PM_REB;
                    start_key    = rd_key;
                    start_hash   = rd_hash;
                    start_bank   = ~ab_reg;
                    start_lg     = nlg_reg;
                end else if (scan_last) begin
                    state_next = phm_pkg::S_RFIN;
                end else begin
                    cnt_next   = cnt_reg + IW'(1);
                    state_next = phm_pkg::S_RSRD;
                end
            end
            phm_pkg::S_RPUT: begin
                if (pr_miss_reg) begin
                    tag_we  = 1'b1;
                    kv_we   = 1'b1;
                    val_we  = 1'b1;
                    wr_key  = mv_key_reg;
                    wr_hash = mv_hash_reg;
                    wr_val  = mv_val_reg;
                end
                if (scan_last) begin
                    state_next = phm_pkg::S_RFIN;
                end else begin
                    cnt_next   = cnt_reg + IW'(1);
                    state_next = phm_pkg::S_RSRD;
                end
            end
            phm_pkg::S_RFIN: begin
                ab_next     = ~ab_reg;
                lg_next     = nlg_reg;
                usable_next = CW'(new_usable - UW'(live_reg));
                start       = 1'b1;
                start_mode  = phm_pkg::PM_RETRY;
                start_bank  = ~ab_reg;
                start_lg    = nlg_reg;
            end
            phm_pkg::S_RETRY: begin
                if (pr_miss_reg && !(pr_empty_reg && usable_reg == '0)) begin
                    state_next = phm_pkg::S_INS;
                end else begin
                    fin        = 1'b1;
                    fin_status = phm_pkg::ST_FULL;
                end
            end
            phm_pkg::S_INS: begin
                tag_we = 1'b1;
                kv_we  = 1'b1;
                val_we = 1'b1;
                if (pr_empty_reg) begin
                    usable_next = usable_reg - CW'(1);
                end
                live_next = live_reg + CW'(1);
                fin       = 1'b1;
            end
            phm_pkg::S_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = phm_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = phm_pkg::S_IDLE;
            end
        endcase

        if (start) begin
            p_mode_next = start_mode;
            p_idx_next  = start_hash[IW-1:0];
            p_pert_next = start_hash;
            p_n_next    = '0;
            p_hf_next   = 1'b0;
            p_bank_next = start_bank;
            p_lg_next   = start_lg;
            p_key_next  = start_key;
            p_hash_next = start_hash;
            state_next  = phm_pkg::S_PRD;
        end
        if (fin) begin
            o_found_next  = fin_found;
            o_val_next    = fin_val;
            o_status_next = fin_status;
            state_next    = phm_pkg::S_OUT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= phm_pkg::S_CLEAR;
            p_mode_reg <= phm_pkg::PM_MAIN;
            cnt_reg    <= '0;
            lg_reg     <= LGW'(MIN_LG);
            nlg_reg    <= LGW'(MIN_LG);
            ab_reg     <= 1'b0;
            live_reg   <= '0;
            usable_reg <= CW'(phm_pkg::usable_of(5'(MIN_LG)));
        end else begin
            state_reg  <= state_next;
            p_mode_reg <= p_mode_next;
            cnt_reg    <= cnt_next;
            lg_reg     <= lg_next;
            nlg_reg    <= nlg_next;
            ab_reg     <= ab_next;
            live_reg   <= live_next;
            usable_reg <= usable_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_idx_reg    <= p_idx_next;
        p_pert_reg   <= p_pert_next;
        p_n_reg      <= p_n_next;
        p_hf_reg     <= p_hf_next;
        p_free_reg   <= p_free_next;
        p_bank_reg   <= p_bank_next;
        p_lg_reg     <= p_lg_next;
        p_key_reg    <= p_key_next;
        p_hash_reg   <= p_hash_next;
        pr_hit_reg   <= pr_hit_next;
        pr_miss_reg  <= pr_miss_next;
        pr_empty_reg <= pr_empty_next;
        slot_reg     <= slot_next;
        pr_val_reg   <= pr_val_next;
        req_op_reg   <= req_op_next;
        req_key_reg  <= req_key_next;
        req_hash_reg <= req_hash_next;
        req_val_reg  <= req_val_next;
        mv_key_reg   <= mv_key_next;
        mv_hash_reg  <= mv_hash_next;
        mv_val_reg   <= mv_val_next;
        o_found_reg  <= o_found_next;
        o_val_reg    <= o_val_next;
        o_status_reg <= o_status_next;
    end

    assign m_tdata = {2'b00, phm_pkg::LIVE_W'(live_reg), o_status_reg, o_val_reg, o_found_reg};

endmodule

`default_nettype wire

// ----- hdl/phm_checker.sv -----
`default_nettype none

module phm_props (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_tvalid,
    input wire logic                     s_tready,
    input wire logic [phm_pkg::IN_W-1:0] s_tdata,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready,
    input wire logic [phm_pkg::OUT_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("request taken while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready stayed high after a request beat");

    a_found_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[66:65] == phm_pkg::ST_DONE)
        else $error("found result with a failure status");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[66:65] != 2'd3)
        else $error("status code out of range");

endmodule

bind perturbed_probe_hash_map phm_props u_phm_props (.*);

`default_nettype wire
